### rtl/core/ivt_pkg.sv
// ----------------------------------------------------------------------------
// ivt_pkg: shared types and constants of the interval value table
// Command codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package ivt_pkg;

  localparam int unsigned DEF_MAX_ENTRIES = 64;
  localparam int unsigned DEF_POS_WIDTH   = 32;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage

### rtl/core/ivt_cell.sv
// ----------------------------------------------------------------------------
// ivt_cell: one entry of the table chain
// Takes its right neighbor's entry on a pop, or one of the emitted entries
// when it sits at the current tail.
// ----------------------------------------------------------------------------
module ivt_cell
  import ivt_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned PW  = DEF_POS_WIDTH,
  parameter int unsigned VW  = DEF_VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          pop,
  input  logic [CW-1:0] base,
  input  logic [1:0]    nemit,
  input  logic [PW-1:0] em_s [3],
  input  logic [PW-1:0] em_l [3],
  input  logic [VW-1:0] em_v [3],
  input  logic [PW-1:0] nb_s,
  input  logic [PW-1:0] nb_l,
  input  logic [VW-1:0] nb_v,
  output logic [PW-1:0] ent_s,
  output logic [PW-1:0] ent_l,
  output logic [VW-1:0] ent_v
);

  logic [PW-1:0] s_r, l_r;
  logic [VW-1:0] v_r;
  logic [CW:0]   d;

  assign d = (CW+1)'(IDX) - {1'b0, base};

  always_ff @(posedge clk) begin
    if (d < {{(CW-1){1'b0}}, nemit}) begin
      s_r <= em_s[d[1:0]];
      l_r <= em_l[d[1:0]];
      v_r <= em_v[d[1:0]];
    end else if (pop) begin
      s_r <= nb_s;
      l_r <= nb_l;
      v_r <= nb_v;
    end
  end

  assign ent_s = s_r;
  assign ent_l = l_r;
  assign ent_v = v_r;

endmodule

### rtl/core/ivt_proc.sv
// ----------------------------------------------------------------------------
// ivt_proc: entry rewrite unit
// Maps the head entry to zero to three new entries for the current command.
// ----------------------------------------------------------------------------
module ivt_proc
  import ivt_pkg::*;
#(
  parameter int unsigned PW = DEF_POS_WIDTH,
  parameter int unsigned VW = DEF_VALUE_WIDTH
) (
  input  cmd_t          cmd,
  input  logic [PW-1:0] s,
  input  logic [PW-1:0] l,
  input  logic [PW-1:0] e,
  input  logic [VW-1:0] v,
  input  logic [PW-1:0] cs,
  input  logic [PW-1:0] cl,
  input  logic [VW-1:0] cv,
  input  logic          placed,
  input  logic          fin,
  output logic [1:0]    nemit,
  output logic [PW-1:0] em_s [3],
  output logic [PW-1:0] em_l [3],
  output logic [VW-1:0] em_v [3],
  output logic          placed_nxt,
  output logic          ch,
  output logic          sat,
  output logic          hit
);

  localparam logic [PW-1:0] MASK = {PW{1'b1}};

  logic [PW-1:0] ce, sx, sl, ns;
  logic [1:0]    k;

  assign ce = cs + cl;

  always_comb begin
    k = 2'd0;
    em_s = '{default: '0};
    em_l = '{default: '0};
    em_v = '{default: '0};
    placed_nxt = placed;
    ch = 1'b0;
    sat = 1'b0;
    hit = 1'b0;
    sx = '0;
    sl = '0;
    ns = '0;
    if (fin) begin
      if (cmd == CMD_SET && !placed) begin
        em_s[k] = s; em_l[k] = l; em_v[k] = v; k = k + 2'd1;
        placed_nxt = 1'b1;
      end
    end else begin
      case (cmd)
        CMD_SET, CMD_CLEAR: begin
          if (ce <= s || cs >= e) begin
            if (!placed && cs >= e) begin
              em_s[k] = s; em_l[k] = l; em_v[k] = v; k = k + 2'd1;
              placed_nxt = 1'b1;
            end
            em_s[k] = cs; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
          end else begin
            ch = 1'b1;
            if (cs < s) begin
              em_s[k] = cs; em_l[k] = s - cs; em_v[k] = cv; k = k + 2'd1;
            end
            if (ce > e) begin
              if (!placed) begin
                em_s[k] = s; em_l[k] = l; em_v[k] = v; k = k + 2'd1;
                placed_nxt = 1'b1;
              end
              em_s[k] = e; em_l[k] = ce - e; em_v[k] = cv; k = k + 2'd1;
            end
          end
        end
        CMD_INSERT: begin
          if (s < ce) begin
            ch = 1'b1;
            if (s <= cs) begin
              sx = cs; sl = cl;
            end else begin
              em_s[k] = cs; em_l[k] = s - cs; em_v[k] = cv; k = k + 2'd1;
              sx = s; sl = ce - s;
            end
            // shifted piece: drop at the top, or cut
            if (l >= MASK - sx) begin
              sat = 1'b1;
            end else begin
              ns = sx + l;
              if (sl > MASK - ns) begin
                sl = MASK - ns;
                sat = 1'b1;
              end
              em_s[k] = ns; em_l[k] = sl; em_v[k] = cv; k = k + 2'd1;
            end
          end else begin
            em_s[k] = cs; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
          end
        end
        CMD_ERASE: begin
          if (l == '0 || ce <= s) begin
            em_s[k] = cs; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
          end else begin
            ch = 1'b1;
            if (e <= cs) begin
              em_s[k] = cs - l; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
            end else if (s <= cs && e >= ce) begin
              k = k;
            end else if (s > cs && e < ce) begin
              em_s[k] = cs; em_l[k] = cl - l; em_v[k] = cv; k = k + 2'd1;
            end else if (s <= cs) begin
              em_s[k] = s; em_l[k] = ce - e; em_v[k] = cv; k = k + 2'd1;
            end else begin
              em_s[k] = cs; em_l[k] = s - cs; em_v[k] = cv; k = k + 2'd1;
            end
          end
        end
        CMD_FIND: begin
          hit = (s >= cs) && (s - cs < cl);
          em_s[k] = cs; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
        end
        default: begin
          em_s[k] = cs; em_l[k] = cl; em_v[k] = cv; k = k + 2'd1;
        end
      endcase
    end
    nemit = k;
  end

endmodule

### rtl/core/interval_value_table.sv
// ----------------------------------------------------------------------------
// interval_value_table: sorted table of tagged, non-overlapping ranges
// Set, clear, insert, erase and find on a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage: drive in_cmd and the operands with start high while busy is low;
// that edge transfers the command. busy stays high until the result has
// been shown. The result appears for one cycle with out_valid high, and the
// receiver takes it then; it cannot stall the block.
// The table lives in a chain of MAX_ENTRIES + 1 cells that rotates through a
// rewrite unit at its head, one entry per cycle; the spare cell holds the
// extra piece of a split while an insert rewrites a full table. A command
// first scans the chain to count the new entries and to look up a find; a
// modifying command that fits then rewrites the chain in a second rotation.
// A find only scans, and a zero-length or unused command does neither.
// A command that would overflow the table is rejected after the scan with
// status 1.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_value_table
  import ivt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int unsigned POS_WIDTH   = DEF_POS_WIDTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_cmd,
  input  logic [POS_WIDTH-1:0]   in_range_start,
  input  logic [POS_WIDTH-1:0]   in_range_length,
  input  logic [VALUE_WIDTH-1:0] in_value_tag,
  output logic                   out_valid,
  output logic                   out_changed,
  output logic                   out_found,
  output logic [31:0]            out_found_start,
  output logic [31:0]            out_found_length,
  output logic [31:0]            out_found_value,
  output logic [1:0]             out_status
);

  localparam int unsigned NC = MAX_ENTRIES + 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 2);
  localparam int unsigned PW = POS_WIDTH;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [PW-1:0] MASK = {PW{1'b1}};

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [PW-1:0] s_r, s_nxt, l_r, l_nxt, e_r, e_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, rem_r, rem_nxt;
  logic [CW:0]   acc_r, acc_nxt;
  logic          placed_r, placed_nxt, ch_r, ch_nxt, sat_r, sat_nxt;
  logic          changed_r, changed_nxt, found_r, found_nxt;
  logic [PW-1:0] fs_r, fs_nxt, fl_r, fl_nxt;
  logic [VW-1:0] fv_r, fv_nxt;
  status_t       status_r, status_nxt;

  logic [PW-1:0] c_s [NC];
  logic [PW-1:0] c_l [NC];
  logic [VW-1:0] c_v [NC];

  logic [1:0]    p_nemit;
  logic [PW-1:0] p_s [3];
  logic [PW-1:0] p_l [3];
  logic [VW-1:0] p_v [3];
  logic          p_placed, p_ch, p_sat, p_hit, fin;

  logic          pop;
  logic [1:0]    nemit;
  logic [PW-1:0] w_s [3];
  logic [PW-1:0] w_l [3];
  logic [VW-1:0] w_v [3];
  logic [CW-1:0] base;
  logic [CW:0]   total;
  logic [PW-1:0] room;
  cmd_t          in_c;

  assign fin  = (rem_r == '0);
  assign pop  = ((state_r == S_SCAN) || (state_r == S_WRITE)) && !fin;
  assign base = cnt_r - {{(CW-1){1'b0}}, pop};
  assign in_c = cmd_t'(in_cmd);
  assign room = MASK - in_range_start;

  ivt_proc #(.PW(PW), .VW(VW)) u_proc (
    .cmd(cmd_r), .s(s_r), .l(l_r), .e(e_r), .v(v_r),
    .cs(c_s[0]), .cl(c_l[0]), .cv(c_v[0]),
    .placed(placed_r), .fin(fin),
    .nemit(p_nemit), .em_s(p_s), .em_l(p_l), .em_v(p_v),
    .placed_nxt(p_placed), .ch(p_ch), .sat(p_sat), .hit(p_hit)
  );

  // scan rotates the chain unchanged; write takes the rewritten entries
  always_comb begin
    w_s = p_s;
    w_l = p_l;
    w_v = p_v;
    nemit = 2'd0;
    if (state_r == S_SCAN) begin
      w_s[0] = c_s[0];
      w_l[0] = c_l[0];
      w_v[0] = c_v[0];
      nemit = pop ? 2'd1 : 2'd0;
    end else if (state_r == S_WRITE) begin
      nemit = p_nemit;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic [PW-1:0] nb_s, nb_l;
    logic [VW-1:0] nb_v;
    if (i + 1 < NC) begin : g_nb
      assign nb_s = c_s[i+1];
      assign nb_l = c_l[i+1];
      assign nb_v = c_v[i+1];
    end else begin : g_last
      assign nb_s = '0;
      assign nb_l = '0;
      assign nb_v = '0;
    end
    ivt_cell #(.IDX(i), .CW(CW), .PW(PW), .VW(VW)) u_cell (
      .clk(clk), .pop(pop), .base(base), .nemit(nemit),
      .em_s(w_s), .em_l(w_l), .em_v(w_v),
      .nb_s(nb_s), .nb_l(nb_l), .nb_v(nb_v),
      .ent_s(c_s[i]), .ent_l(c_l[i]), .ent_v(c_v[i])
    );
  end

  assign total = acc_r + {{(CW-1){1'b0}}, p_nemit};

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    s_nxt = s_r; l_nxt = l_r; e_nxt = e_r; v_nxt = v_r;
    cnt_nxt = cnt_r - {{(CW-1){1'b0}}, pop} + {{(CW-2){1'b0}}, nemit};
    n_nxt = n_r; rem_nxt = rem_r; acc_nxt = acc_r;
    placed_nxt = placed_r; ch_nxt = ch_r; sat_nxt = sat_r;
    changed_nxt = changed_r; found_nxt = found_r;
    fs_nxt = fs_r; fl_nxt = fl_r; fv_nxt = fv_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_c;
          s_nxt = in_range_start;
          v_nxt = in_value_tag;
          l_nxt = in_range_length;
          changed_nxt = 1'b0; found_nxt = 1'b0;
          fs_nxt = '0; fl_nxt = '0; fv_nxt = '0;
          status_nxt = ST_OK;
          n_nxt = cnt_r; rem_nxt = cnt_r; acc_nxt = '0;
          placed_nxt = (in_c == CMD_CLEAR);
          ch_nxt = 1'b0; sat_nxt = 1'b0;
          state_nxt = S_RESP;
          if ((in_c == CMD_SET || in_c == CMD_CLEAR || in_c == CMD_ERASE)
              && in_range_length > room) begin
            l_nxt = room;
            if (in_c != CMD_ERASE) status_nxt = ST_SAT;
          end
          e_nxt = in_range_start + l_nxt;
          case (in_c)
            CMD_SET, CMD_CLEAR: begin
              if (l_nxt != '0) state_nxt = S_SCAN;
            end
            CMD_INSERT, CMD_ERASE: begin
              if (in_range_length != '0) state_nxt = S_SCAN;
            end
            CMD_FIND: state_nxt = S_SCAN;
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        acc_nxt = total;
        placed_nxt = p_placed;
        if (p_sat) sat_nxt = 1'b1;
        if (!fin) begin
          rem_nxt = rem_r - CW'(1);
          if (p_hit && !found_r) begin
            found_nxt = 1'b1;
            fs_nxt = c_s[0]; fl_nxt = c_l[0]; fv_nxt = c_v[0];
          end
        end else if (cmd_r == CMD_FIND) begin
          state_nxt = S_RESP;
        end else if (cmd_r != CMD_ERASE && total > (CW+1)'(MAX_ENTRIES)) begin
          status_nxt = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          if (cmd_r == CMD_INSERT && sat_r) status_nxt = ST_SAT;
          rem_nxt = n_r;
          placed_nxt = (cmd_r == CMD_CLEAR);
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        placed_nxt = p_placed;
        if (p_ch) ch_nxt = 1'b1;
        if (!fin) begin
          rem_nxt = rem_r - CW'(1);
        end else begin
          changed_nxt = ch_r || (cmd_r == CMD_SET);
          state_nxt = S_RESP;
        end
      end
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    s_r <= s_nxt; l_r <= l_nxt; e_r <= e_nxt; v_r <= v_nxt;
    n_r <= n_nxt; acc_r <= acc_nxt;
    placed_r <= placed_nxt; ch_r <= ch_nxt; sat_r <= sat_nxt;
    changed_r <= changed_nxt; found_r <= found_nxt;
    fs_r <= fs_nxt; fl_r <= fl_nxt; fv_r <= fv_nxt;
    status_r <= status_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_RESP);
  assign out_changed      = changed_r;
  assign out_found        = found_r;
  assign out_found_start  = 32'(fs_r);
  assign out_found_length = 32'(fl_r);
  assign out_found_value  = 32'(fv_r);
  assign out_status       = status_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r <= CW'(MAX_ENTRIES))) else $error("count overflow");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command not taken");
  a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && (state_nxt == S_RESP)) |=> (cnt_r == $past(n_r)))
    else $error("scan altered the table");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for the interval value table
// A table of directed commands, then random commands checked against a
// predictor that keeps its own copy of the sorted range table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ivt_pkg::*;

  localparam int unsigned DEPTH = DEF_MAX_ENTRIES;
  localparam longint unsigned TOP = 64'hFFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        changed;
    logic        found;
    logic [31:0] fstart;
    logic [31:0] flength;
    logic [31:0] fvalue;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] rstart;
    logic [31:0] rlength;
    logic [31:0] tag;
    logic        fixed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [31:0] in_range_start = '0;
  logic [31:0] in_range_length = '0;
  logic [31:0] in_value_tag = '0;
  logic        out_valid;
  logic        out_changed;
  logic        out_found;
  logic [31:0] out_found_start;
  logic [31:0] out_found_length;
  logic [31:0] out_found_value;
  logic [1:0]  out_status;

  always #5 clk = ~clk;

  interval_value_table i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_range_start(in_range_start),
    .in_range_length(in_range_length), .in_value_tag(in_value_tag),
    .out_valid(out_valid), .out_changed(out_changed), .out_found(out_found),
    .out_found_start(out_found_start), .out_found_length(out_found_length),
    .out_found_value(out_found_value), .out_status(out_status)
  );

  // predictor's copy of the table
  longint unsigned tbl_s[DEPTH];
  longint unsigned tbl_l[DEPTH];
  longint unsigned tbl_v[DEPTH];
  int unsigned     tbl_n = 0;
  longint unsigned nx_s[DEPTH+2];
  longint unsigned nx_l[DEPTH+2];
  longint unsigned nx_v[DEPTH+2];
  int unsigned     nx_n;
  bit              nx_sat;

  answer_t pending_answers[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  function automatic void push_entry(longint unsigned s, longint unsigned l,
                                     longint unsigned v);
    if (nx_n < DEPTH + 2) begin
      nx_s[nx_n] = s; nx_l[nx_n] = l; nx_v[nx_n] = v;
    end
    nx_n++;
  endfunction

  function automatic void push_moved(longint unsigned s, longint unsigned l,
                                     longint unsigned v, longint unsigned sh);
    longint unsigned ns;
    if (sh >= TOP - s) begin
      nx_sat = 1'b1;
      return;
    end
    ns = s + sh;
    if (l > TOP - ns) begin
      l = TOP - ns;
      nx_sat = 1'b1;
    end
    push_entry(ns, l, v);
  endfunction

  function automatic bit install_table();
    if (nx_n > DEPTH) return 1'b0;
    for (int unsigned i = 0; i < nx_n; i++) begin
      tbl_s[i] = nx_s[i]; tbl_l[i] = nx_l[i]; tbl_v[i] = nx_v[i];
    end
    tbl_n = nx_n;
    return 1'b1;
  endfunction

  function automatic answer_t apply_command(logic [2:0] cmd, logic [31:0] rs,
                                            logic [31:0] rl, logic [31:0] tg);
    answer_t a;
    longint unsigned s, l, v, e, cs, cl, cv, ce;
    bit placed, ch;
    a = '0;
    s = rs; l = rl; v = tg;
    ch = 1'b0;
    nx_n = 0;
    nx_sat = 1'b0;
    if ((cmd == CMD_SET || cmd == CMD_CLEAR) && l != 0) begin
      placed = (cmd == CMD_CLEAR);
      if (l > TOP - s) begin
        l = TOP - s;
        a.status = ST_SAT;
      end
      if (l != 0) begin
        e = s + l;
        for (int unsigned i = 0; i < tbl_n; i++) begin
          cs = tbl_s[i]; cl = tbl_l[i]; cv = tbl_v[i]; ce = cs + cl;
          if (ce <= s || cs >= e) begin
            if (!placed && cs >= e) begin
              push_entry(s, l, v);
              placed = 1'b1;
            end
            push_entry(cs, cl, cv);
          end else begin
            ch = 1'b1;
            if (cs < s) push_entry(cs, s - cs, cv);
            if (ce > e) begin
              if (!placed) begin
                push_entry(s, l, v);
                placed = 1'b1;
              end
              push_entry(e, ce - e, cv);
            end
          end
        end
        if (!placed) push_entry(s, l, v);
        if (cmd == CMD_SET) ch = 1'b1;
        if (install_table()) a.changed = ch;
        else a.status = ST_FULL;
      end
    end else if (cmd == CMD_INSERT && l != 0) begin
      for (int unsigned i = 0; i < tbl_n; i++) begin
        cs = tbl_s[i]; cl = tbl_l[i]; cv = tbl_v[i]; ce = cs + cl;
        if (s <= cs) begin
          push_moved(cs, cl, cv, l);
          ch = 1'b1;
        end else if (s < ce) begin
          push_entry(cs, s - cs, cv);
          push_moved(s, ce - s, cv, l);
          ch = 1'b1;
        end else begin
          push_entry(cs, cl, cv);
        end
      end
      if (install_table()) begin
        a.changed = ch;
        a.status = nx_sat ? ST_SAT : ST_OK;
      end else begin
        a.status = ST_FULL;
      end
    end else if (cmd == CMD_ERASE && l != 0) begin
      if (l > TOP - s) l = TOP - s;
      e = s + l;
      for (int unsigned i = 0; i < tbl_n; i++) begin
        cs = tbl_s[i]; cl = tbl_l[i]; cv = tbl_v[i]; ce = cs + cl;
        if (l == 0 || ce <= s) begin
          push_entry(cs, cl, cv);
        end else if (e <= cs) begin
          push_entry(cs - l, cl, cv);
          ch = 1'b1;
        end else if (s <= cs && e >= ce) begin
          ch = 1'b1;
        end else if (s > cs && e < ce) begin
          push_entry(cs, cl - l, cv);
          ch = 1'b1;
        end else if (s <= cs) begin
          push_entry(s, ce - e, cv);
          ch = 1'b1;
        end else begin
          push_entry(cs, s - cs, cv);
          ch = 1'b1;
        end
      end
      if (install_table()) a.changed = ch;
      else a.status = ST_FULL;
    end else if (cmd == CMD_FIND) begin
      for (int unsigned i = 0; i < tbl_n; i++) begin
        if (s >= tbl_s[i] && s - tbl_s[i] < tbl_l[i]) begin
          a.found = 1'b1;
          a.fstart = tbl_s[i][31:0];
          a.flength = tbl_l[i][31:0];
          a.fvalue = tbl_v[i][31:0];
          break;
        end
      end
    end
    return a;
  endfunction

  // result monitor
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_changed, out_found, out_found_start, out_found_length,
              out_found_value, out_status};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected chg=%b fnd=%b s=%h l=%h v=%h st=%0d,",
                      " got chg=%b fnd=%b s=%h l=%h v=%h st=%0d"},
                     want.changed, want.found, want.fstart, want.flength,
                     want.fvalue, want.status, got.changed, got.found,
                     got.fstart, got.flength, got.fvalue, got.status);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("interval_value_table regression: fail");
      $finish;
    end
  end

  // start stays high between back-to-back commands; drop it only for an idle burst
  task automatic send_command(logic [2:0] cmd, logic [31:0] rs, logic [31:0] rl,
                              logic [31:0] tg, bit fixed, answer_t fixed_ans);
    answer_t a;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= cmd; in_range_start <= rs; in_range_length <= rl; in_value_tag <= tg;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    a = apply_command(cmd, rs, rl, tg);
    pending_answers.push_back(fixed ? fixed_ans : a);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  row_t directed[$];

  initial begin
    answer_t none;
    logic [2:0] c;
    none = '0;
    directed.push_back('{CMD_FIND, 32'd5, 32'd0, 32'd0, 1'b1, none});
    directed.push_back('{CMD_SET, 32'd5, 32'd0, 32'd1, 1'b1, none});
    directed.push_back('{CMD_INSERT, 32'd5, 32'd0, 32'd0, 1'b1, none});
    directed.push_back('{CMD_ERASE, 32'd5, 32'd0, 32'd0, 1'b1, none});
    directed.push_back('{3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, none});
    directed.push_back('{3'd6, 32'd1, 32'd1, 32'd1, 1'b1, none});
    directed.push_back('{3'd7, 32'd1, 32'd1, 32'd1, 1'b1, none});
    directed.push_back('{CMD_SET, 32'd10, 32'd20, 32'hFFFF_FFFF, 1'b1,
                         '{1'b1, 1'b0, 32'd0, 32'd0, 32'd0, ST_OK}});
    directed.push_back('{CMD_FIND, 32'd10, 32'd0, 32'd0, 1'b1,
                         '{1'b0, 1'b1, 32'd10, 32'd20, 32'hFFFF_FFFF, ST_OK}});
    directed.push_back('{CMD_FIND, 32'd30, 32'd0, 32'd0, 1'b1, none});
    directed.push_back('{CMD_SET, 32'd15, 32'd5, 32'd7, 1'b0, none});
    directed.push_back('{CMD_CLEAR, 32'd12, 32'd2, 32'd0, 1'b0, none});
    directed.push_back('{CMD_INSERT, 32'd11, 32'd100, 32'd0, 1'b0, none});
    directed.push_back('{CMD_ERASE, 32'd0, 32'd50, 32'd0, 1'b0, none});
    directed.push_back('{CMD_SET, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd3, 1'b1,
                         '{1'b1, 1'b0, 32'd0, 32'd0, 32'd0, ST_SAT}});
    // nothing left above the top position: saturated, table untouched
    directed.push_back('{CMD_SET, 32'hFFFF_FFFF, 32'd1, 32'd3, 1'b1,
                         '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0, ST_SAT}});
    directed.push_back('{CMD_FIND, 32'hFFFF_FFFE, 32'd0, 32'd0, 1'b0, none});
    directed.push_back('{CMD_INSERT, 32'd0, 32'hFFFF_FFF8, 32'd0, 1'b0, none});
    directed.push_back('{CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, none});
    directed.push_back('{CMD_SET, 32'd0, 32'd4, 32'd9, 1'b0, none});
    directed.push_back('{CMD_ERASE, 32'd2, 32'hFFFF_FFFF, 32'd0, 1'b0, none});
    directed.push_back('{CMD_CLEAR, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, none});
    directed.push_back('{CMD_FIND, 32'd0, 32'd0, 32'd0, 1'b1, none});

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send_command(directed[i].cmd, directed[i].rstart, directed[i].rlength,
                   directed[i].tag, directed[i].fixed, directed[i].ans);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > RANDOM_ITEMS - 150) quiet = 1'b1;
      // fill the table with many small entries at times to reach the full case
      if ($urandom_range(0, 2) == 0)
        send_command(CMD_SET, $urandom_range(0, 70) * 3, 32'd1, $urandom(), 1'b0, none);
      else if ($urandom_range(0, 30) == 0)
        send_command(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                     1'b0, none);
      else begin
        c = 3'($urandom_range(0, 4));
        send_command(c, pick_pos(), pick_len(), $urandom(), 1'b0, none);
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("interval_value_table regression: pass");
    else
      $display("interval_value_table regression: fail");
    $finish;
  end

endmodule
